// File: sv/gbos_pkg.sv
// Shared constants and types for the grouped box overlap search.
`timescale 1ns / 1ps
`default_nettype none
package gbos_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int NUM_GROUPS  = 8;
    localparam int GROUP_W     = 3;
    localparam int COORD_BITS  = 16;
    localparam int STORE_W     = COORD_BITS + 1;
    localparam int QUERY_W     = COORD_BITS + 2;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [GROUP_W-1:0]        group;
        logic signed [STORE_W-1:0] left;
        logic signed [STORE_W-1:0] right;
        logic signed [STORE_W-1:0] top;
        logic signed [STORE_W-1:0] bottom;
    } entry_t;

    typedef struct packed {
        logic [GROUP_W-1:0]        group;
        logic signed [QUERY_W-1:0] left;
        logic signed [QUERY_W-1:0] right;
        logic signed [QUERY_W-1:0] top;
        logic signed [QUERY_W-1:0] bottom;
    } query_t;

endpackage
`default_nettype wire

// File: sv/gbos_entry_ram.sv
// Simple dual-port synchronous RAM holding the stored boxes.
`timescale 1ns / 1ps
`default_nettype none
module gbos_entry_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: sv/gbos_overlap.sv
// Strict overlap test of one query box against one stored box of another group.
`timescale 1ns / 1ps
`default_nettype none
module gbos_overlap
    import gbos_pkg::*;
(
    input  wire query_t query,
    input  wire entry_t entry,
    output logic        match
);

    logic signed [QUERY_W-1:0] e_left;
    logic signed [QUERY_W-1:0] e_right;
    logic signed [QUERY_W-1:0] e_top;
    logic signed [QUERY_W-1:0] e_bottom;

    always_comb begin
        e_left   = QUERY_W'(entry.left);
        e_right  = QUERY_W'(entry.right);
        e_top    = QUERY_W'(entry.top);
        e_bottom = QUERY_W'(entry.bottom);
        match = (entry.group != query.group)
             && (query.left < e_right) && (e_left < query.right)
             && (query.bottom > e_top) && (query.top < e_bottom);
    end

endmodule
`default_nettype wire

// File: sv/grouped_box_overlap_search.sv
// Top level: box table control, query scan and result register.
// An add writes the table in its accept cycle. A query's scan reads one stored box
// per cycle from the single read port of the table memory.
// Synchronous active-low reset clears the state, the count, the overflow and hit
// flags and the valid flag of the result register; the result data and the table
// memory contents are not cleared, and the table needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module grouped_box_overlap_search
    import gbos_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_kind,
    input  wire logic [GROUP_W-1:0]           s_group,
    input  wire logic signed [COORD_BITS-1:0] s_box_left,
    input  wire logic signed [COORD_BITS-1:0] s_box_top,
    input  wire logic signed [COORD_BITS-1:0] s_box_right,
    input  wire logic signed [COORD_BITS-1:0] s_box_bottom,
    input  wire logic signed [COORD_BITS-1:0] s_pos_x,
    input  wire logic signed [COORD_BITS-1:0] s_pos_y,
    input  wire logic signed [COORD_BITS-1:0] s_offset_x,
    input  wire logic signed [COORD_BITS-1:0] s_offset_y,
    input  wire logic                         s_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_collide,
    output logic                              m_table_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             hit_reg, hit_next;
    logic             overflow_reg, overflow_next;
    logic             last_reg, last_next;
    query_t           query_reg, query_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_collide_reg, m_collide_next;
    logic             m_full_reg, m_full_next;

    logic                      accept;
    logic                      issuing;
    logic                      wr_en;
    entry_t                    wr_entry;
    entry_t                    rd_entry;
    logic                      match;
    logic signed [QUERY_W-1:0] abs_x;
    logic signed [QUERY_W-1:0] abs_y;
    query_t                    query_in;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign issuing      = (state_reg == ST_SCAN) && (scan_idx_reg != count_reg);
    assign m_valid      = m_valid_reg;
    assign m_collide    = m_collide_reg;
    assign m_table_full = m_full_reg;

    always_comb begin
        wr_entry.group  = s_group;
        wr_entry.left   = STORE_W'(s_box_left) + STORE_W'(s_pos_x);
        wr_entry.right  = STORE_W'(s_box_right) + STORE_W'(s_pos_x);
        wr_entry.top    = STORE_W'(s_box_top) + STORE_W'(s_pos_y);
        wr_entry.bottom = STORE_W'(s_box_bottom) + STORE_W'(s_pos_y);

        abs_x           = QUERY_W'(s_pos_x) + QUERY_W'(s_offset_x);
        abs_y           = QUERY_W'(s_pos_y) + QUERY_W'(s_offset_y);
        query_in.group  = s_group;
        query_in.left   = QUERY_W'(s_box_left) + abs_x;
        query_in.right  = QUERY_W'(s_box_right) + abs_x;
        query_in.top    = QUERY_W'(s_box_top) + abs_y;
        query_in.bottom = QUERY_W'(s_box_bottom) + abs_y;
    end

    assign wr_en = accept && (s_kind == KIND_ADD)
                && ({1'b0, s_group} < (GROUP_W + 1)'(NUM_GROUPS))
                && (count_reg != CNT_W'(MAX_ENTRIES));

    gbos_entry_ram #(
        .WIDTH  ($bits(entry_t)),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    gbos_overlap u_overlap (
        .query (query_reg),
        .entry (rd_entry),
        .match (match)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        hit_next       = hit_reg;
        overflow_next  = overflow_reg;
        last_next      = last_reg;
        query_next     = query_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_collide_next = m_collide_reg;
        m_full_next    = m_full_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_ADD: begin
                            if (wr_en) begin
                                count_next = count_reg + CNT_W'(1);
                            end else if ({1'b0, s_group} < (GROUP_W + 1)'(NUM_GROUPS)) begin
                                overflow_next = 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            query_next    = query_in;
                            last_next     = s_last;
                            scan_idx_next = '0;
                            state_next    = hit_reg ? ST_DONE : ST_SCAN;
                        end
                        KIND_CLEAR: begin
                            count_next    = '0;
                            overflow_next = 1'b0;
                            hit_next      = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (cmp_valid_reg && match) begin
                    hit_next = 1'b1;
                end
                if (issuing) begin
                    scan_idx_next  = scan_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end else if (!cmp_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_collide_next = hit_reg;
                    m_full_next    = overflow_reg;
                    hit_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            overflow_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            overflow_reg  <= overflow_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        last_reg      <= last_next;
        query_reg     <= query_next;
        m_collide_reg <= m_collide_next;
        m_full_reg    <= m_full_next;
    end

endmodule
`default_nettype wire
